FILE: sv/stereo_channel_strip_defines.svh
// Assertion macros shared by the channel strip checker.
// No dependencies; included by scs_checker.sv.
`ifndef STEREO_CHANNEL_STRIP_DEFINES_SVH
`define STEREO_CHANNEL_STRIP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCS_HOLDS(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("channel strip check failed");

// Next-cycle implication, disabled during reset.
`define SCS_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("channel strip check failed");

`endif

FILE: sv/scs_pkg.sv
// Shared types and constants for the stereo channel strip.
// No dependencies; used by scs_ctrl, scs_datapath and stereo_channel_strip.
`default_nettype none

package scs_pkg;

  localparam int DELAY_DEPTH_DEF = 8192;
  localparam int SINE_SIZE_DEF   = 256;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0]        DECAY_Q16   = 16'd62259;
  localparam logic [15:0]        VOL_MAX     = 16'd32768;
  localparam logic signed [15:0] PAN_LIM     = 16'sd16384;
  localparam logic [22:0]        MAG_MAX     = 23'h7FFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME,
    REG_PAN,
    REG_PHASE,
    REG_MONO,
    REG_MUTE,
    REG_LATENCY
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB,
    ST_BS0,
    ST_BS1,
    ST_BC0,
    ST_BC1,
    ST_VGL,
    ST_VGR,
    ST_GL,
    ST_GR,
    ST_ML,
    ST_MR,
    ST_DLY,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_BS0,
    MOP_BS1,
    MOP_BC0,
    MOP_BC1,
    MOP_VGL,
    MOP_VGR,
    MOP_GL,
    MOP_GR,
    MOP_ML,
    MOP_MR
  } mop_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic tab;
    mop_t mop;
    logic dly;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/scs_ctrl.sv
// Sequencer for the channel strip: clearing pass, then one beat at a time.
// Depends on scs_pkg.
`default_nettype none

module scs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  scs_pkg::sts_t     sts,
  output scs_pkg::cmd_t     cmd
);
  import scs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mop    = MOP_NONE;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_TAB;
        end
      end
      ST_TAB: begin
        cmd.tab    = 1'b1;
        state_next = ST_BS0;
      end
      ST_BS0: begin cmd.mop = MOP_BS0; state_next = ST_BS1; end
      ST_BS1: begin cmd.mop = MOP_BS1; state_next = ST_BC0; end
      ST_BC0: begin cmd.mop = MOP_BC0; state_next = ST_BC1; end
      ST_BC1: begin cmd.mop = MOP_BC1; state_next = ST_VGL; end
      ST_VGL: begin cmd.mop = MOP_VGL; state_next = ST_VGR; end
      ST_VGR: begin cmd.mop = MOP_VGR; state_next = ST_GL;  end
      ST_GL:  begin cmd.mop = MOP_GL;  state_next = ST_GR;  end
      ST_GR:  begin cmd.mop = MOP_GR;  state_next = ST_ML;  end
      ST_ML:  begin cmd.mop = MOP_ML;  state_next = ST_MR;  end
      ST_MR:  begin cmd.mop = MOP_MR;  state_next = ST_DLY; end
      ST_DLY: begin
        cmd.dly    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/scs_datapath.sv
// Datapath: config registers, pan table, shared multiplier, meters,
// delay memory and output register. Depends on scs_pkg.
`default_nettype none

module scs_datapath #(
  parameter int DELAY_DEPTH     = scs_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = scs_pkg::SINE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scs_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic signed [23:0]            in_left,
  input  wire logic signed [23:0]            in_right,
  input  wire logic                          last_in_block,
  input  scs_pkg::cmd_t                      cmd,
  output scs_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [23:0]                 out_left,
  output logic signed [23:0]                 out_right,
  output logic [22:0]                        meter_left,
  output logic [22:0]                        meter_right
);
  import scs_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int IW = $clog2(SINE_TABLE_SIZE + 1);
  localparam int PW = 16 + IW;

  function automatic logic signed [23:0] sat_gain(input logic [63:0] pr, input logic neg);
    logic [63:0] r;
    begin
      r = (pr + 64'd536870912) >> 30;
      if (neg) begin
        if (r > 64'd8388608) r = 64'd8388608;
        sat_gain = 24'(-r);
      end else begin
        if (r > 64'd8388607) r = 64'd8388607;
        sat_gain = 24'(r);
      end
    end
  endfunction

  function automatic logic [22:0] mag23(input logic signed [23:0] v);
    logic [24:0] m;
    begin
      m = v[23] ? 25'(-25'(v)) : 25'(v);
      mag23 = (m > 25'(MAG_MAX)) ? MAG_MAX : m[22:0];
    end
  endfunction

  // configuration
  logic [15:0]        volume;
  logic signed [15:0] pan;
  logic               phase_invert;
  logic               force_mono;
  logic               mute;
  logic [12:0]        latency;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume       <= 16'd16384;
      pan          <= '0;
      phase_invert <= 1'b0;
      force_mono   <= 1'b0;
      mute         <= 1'b0;
      latency      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOLUME:  volume       <= cfg_data;
        REG_PAN:     pan          <= cfg_data;
        REG_PHASE:   phase_invert <= cfg_data[0];
        REG_MONO:    force_mono   <= cfg_data[0];
        REG_MUTE:    mute         <= cfg_data[0];
        REG_LATENCY: latency      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table, Q1.16, built at elaboration
  logic [16:0] sine_tab [SINE_TABLE_SIZE+1];

  for (genvar i = 0; i <= SINE_TABLE_SIZE; i++) begin : g_sine
    localparam logic [63:0] X  = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_SIZE);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] S1 = (T1 > X) ? 64'd0 : X - T1;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] S2 = S1 + T2;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] S3 = (T3 > S2) ? 64'd0 : S2 - T3;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] S4 = S3 + T4;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] S5 = (T5 > S4) ? 64'd0 : S4 - T5;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] S6 = S5 + T6;
    localparam logic [63:0] R  = (S6 + 64'd8192) >> 14;
    localparam logic [63:0] E  = (R > 64'd65536) ? 64'd65536 : R;
    assign sine_tab[i] = E[16:0];
  end

  // pan position
  logic signed [15:0] pan_c;
  logic [15:0]        pan_p;
  logic [PW-1:0]      pos;
  logic [IW-1:0]      idx, idx_s1, idx_c0, idx_c1;
  logic [14:0]        frac;
  logic               idx_end;
  logic [15:0]        vol_c;

  always_comb begin
    if (pan < -PAN_LIM)     pan_c = -PAN_LIM;
    else if (pan > PAN_LIM) pan_c = PAN_LIM;
    else                    pan_c = pan;
    pan_p   = 16'(pan_c + PAN_LIM);
    pos     = PW'(pan_p) * PW'(SINE_TABLE_SIZE);
    idx     = IW'(pos >> 15);
    frac    = pos[14:0];
    idx_end = (idx == IW'(SINE_TABLE_SIZE));
    idx_s1  = idx_end ? idx : IW'(idx + 1'b1);
    idx_c0  = IW'(IW'(SINE_TABLE_SIZE) - idx);
    idx_c1  = idx_end ? '0 : IW'(idx_c0 - 1'b1);
    vol_c   = (volume > VOL_MAX) ? VOL_MAX : volume;
  end

  // input capture: phase inversion and mono fold
  logic signed [24:0] s_l, s_r;
  logic               last_q;
  logic signed [24:0] inv_l, inv_r;
  logic signed [25:0] mono_sum;

  always_comb begin
    inv_l    = phase_invert ? 25'(-25'(in_left))  : 25'(in_left);
    inv_r    = phase_invert ? 25'(-25'(in_right)) : 25'(in_right);
    mono_sum = 26'(inv_l) + 26'(inv_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_q <= last_in_block;
      if (force_mono) begin
        s_l <= 25'(mono_sum >>> 1);
        s_r <= 25'(mono_sum >>> 1);
      end else begin
        s_l <= inv_l;
        s_r <= inv_r;
      end
    end
  end

  logic [23:0] mag_l, mag_r;
  assign mag_l = s_l[24] ? 24'(-s_l) : 24'(s_l);
  assign mag_r = s_r[24] ? 24'(-s_r) : 24'(s_r);

  // shared multiplier
  logic [16:0]        ts_a, ts_b, tc_a, tc_b;
  logic [31:0]        acc;
  logic [16:0]        gsin, gcos;
  logic [31:0]        vgl, vgr;
  logic signed [23:0] res_l, res_r;
  logic [22:0]        peak_l, peak_r, level_l, level_r;
  logic [31:0]        ma, mb;
  logic [63:0]        prod;
  logic [32:0]        blend_sum;
  logic [15:0]        frac_inv;
  logic [22:0]        peak_eff_l, peak_eff_r;

  assign frac_inv = 16'd32768 - 16'(frac);

  always_comb begin
    unique case (cmd.mop)
      MOP_BS0: begin ma = 32'(ts_a);    mb = 32'(frac_inv);  end
      MOP_BS1: begin ma = 32'(ts_b);    mb = 32'(frac);      end
      MOP_BC0: begin ma = 32'(tc_a);    mb = 32'(frac_inv);  end
      MOP_BC1: begin ma = 32'(tc_b);    mb = 32'(frac);      end
      MOP_VGL: begin ma = 32'(vol_c);   mb = 32'(gcos);      end
      MOP_VGR: begin ma = 32'(vol_c);   mb = 32'(gsin);      end
      MOP_GL:  begin ma = 32'(mag_l);   mb = vgl;            end
      MOP_GR:  begin ma = 32'(mag_r);   mb = vgr;            end
      MOP_ML:  begin ma = 32'(level_l); mb = 32'(DECAY_Q16); end
      MOP_MR:  begin ma = 32'(level_r); mb = 32'(DECAY_Q16); end
      default: begin ma = '0;           mb = '0;             end
    endcase
    prod       = 64'(ma) * 64'(mb);
    blend_sum  = 33'(acc) + 33'(prod[31:0]) + 33'd16384;
    peak_eff_l = (mag23(res_l) > peak_l) ? mag23(res_l) : peak_l;
    peak_eff_r = (mag23(res_r) > peak_r) ? mag23(res_r) : peak_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.tab) begin
      ts_a <= sine_tab[idx];
      ts_b <= sine_tab[idx_s1];
      tc_a <= sine_tab[idx_c0];
      tc_b <= sine_tab[idx_c1];
    end
    unique case (cmd.mop)
      MOP_BS0, MOP_BC0: acc   <= prod[31:0];
      MOP_BS1:          gsin  <= blend_sum[31:15];
      MOP_BC1:          gcos  <= blend_sum[31:15];
      MOP_VGL:          vgl   <= prod[31:0];
      MOP_VGR:          vgr   <= prod[31:0];
      MOP_GL:           res_l <= sat_gain(prod, s_l[24]);
      MOP_GR:           res_r <= sat_gain(prod, s_r[24]);
      default: ;
    endcase
  end

  // metering
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_l  <= '0;
      peak_r  <= '0;
      level_l <= '0;
      level_r <= '0;
    end else if (cmd.mop == MOP_ML) begin
      if (last_q) begin
        level_l <= (peak_eff_l > level_l) ? peak_eff_l : prod[38:16];
        peak_l  <= '0;
      end else begin
        peak_l  <= peak_eff_l;
      end
    end else if (cmd.mop == MOP_MR) begin
      if (last_q) begin
        level_r <= (peak_eff_r > level_r) ? peak_eff_r : prod[38:16];
        peak_r  <= '0;
      end else begin
        peak_r  <= peak_eff_r;
      end
    end
  end

  // delay line
  logic [47:0]        mem [DELAY_DEPTH];
  logic [47:0]        rd_q;
  logic [AW-1:0]      wp, wp_inc, rp, lat;
  logic               lat_on;
  logic signed [23:0] mv_l, mv_r;

  always_comb begin
    lat    = ({19'd0, latency} >= 32'(DELAY_DEPTH)) ? AW'(DELAY_DEPTH - 1) : AW'(latency);
    lat_on = (lat != '0);
    rp     = (wp >= lat) ? AW'(wp - lat) : AW'(32'(wp) + 32'(DELAY_DEPTH) - 32'(lat));
    wp_inc = (wp == AW'(DELAY_DEPTH - 1)) ? '0 : AW'(wp + 1'b1);
    mv_l   = mute ? '0 : res_l;
    mv_r   = mute ? '0 : res_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[wp] <= '0;
    end else if (cmd.dly && lat_on) begin
      mem[wp] <= {mv_l, mv_r};
    end
    if (cmd.dly) rd_q <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.clr || (cmd.dly && lat_on)) begin
      wp <= wp_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_left    <= lat_on ? rd_q[47:24] : mv_l;
      out_right   <= lat_on ? rd_q[23:0]  : mv_r;
      meter_left  <= level_l;
      meter_right <= level_r;
    end
  end

  assign sts.clr_last = (wp == AW'(DELAY_DEPTH - 1));
  assign sts.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

FILE: sv/stereo_channel_strip.sv
// Stereo channel strip: phase invert, mono fold, volume with equal-power
// pan, peak meters, mute and an output delay shared by both channels.
//
// Input channel: in_valid / in_stall carry one stereo pair per beat
// (in_left, in_right, last_in_block). A beat is taken when in_valid is high
// and in_stall is low.
// Output channel: out_valid / out_stall carry one result per input beat
// (out_left, out_right, meter_left, meter_right), held while stalled.
// One beat is taken at a time: the next beat waits until the result has
// been loaded into the output register. The gains, products and meter decay
// all go through one shared 32x32 multiplier, one operation per cycle.
// A waiting result does not block the next input beat; only the final
// load of the output register waits while out_stall is high.
// Reset: the delay memory is swept to zero with in_stall high; configuration
// writes are taken during the sweep.
// Config port: cfg_write with cfg_index 0..5 = volume, pan, phase_invert,
// force_mono, mute, latency. Write only while no beat is in flight.
// Depends on scs_pkg, scs_ctrl, scs_datapath.
`default_nettype none

module stereo_channel_strip #(
  parameter int DELAY_DEPTH     = scs_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = scs_pkg::SINE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scs_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [23:0]            in_left,
  input  wire logic signed [23:0]            in_right,
  input  wire logic                          last_in_block,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [23:0]                 out_left,
  output logic signed [23:0]                 out_right,
  output logic [22:0]                        meter_left,
  output logic [22:0]                        meter_right
);
  import scs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the input handshake
  scs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // all arithmetic, storage and the output register
  scs_datapath #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left       (in_left),
    .in_right      (in_right),
    .last_in_block (last_in_block),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left      (out_left),
    .out_right     (out_right),
    .meter_left    (meter_left),
    .meter_right   (meter_right)
  );

endmodule

`default_nettype wire

FILE: sv/scs_checker.sv
// Port-level checks for the channel strip, bound to the top level.
// Depends on stereo_channel_strip_defines.svh.
`default_nettype none
`include "stereo_channel_strip_defines.svh"

module scs_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [23:0] out_left,
  input wire logic signed [23:0] out_right
);

  // one beat at a time: a taken beat closes the input
  `SCS_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)

  // a new result only appears while the input side is closed
  `SCS_HOLDS(a_result_while_busy, clk, rst, $rose(out_valid), $past(in_stall))

  // a stalled result holds
  `SCS_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
            out_valid && $stable(out_left) && $stable(out_right))

endmodule

bind stereo_channel_strip scs_checker u_scs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_left  (out_left),
  .out_right (out_right)
);

`default_nettype wire
